// ----- sv/key_matrix_debounce_scan_unit_macros.svh -----
// Assertion macros shared by the key matrix debounce scan unit.
`ifndef KEY_MATRIX_DEBOUNCE_SCAN_UNIT_MACROS_SVH
`define KEY_MATRIX_DEBOUNCE_SCAN_UNIT_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define KMDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next.
`define KMDS_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ----- sv/kmds_pkg.sv -----
// Package with sizes and constants of the key matrix debounce scan unit.
package kmds_pkg;

  localparam int ROWS      = 4;
  localparam int COLS      = 6;
  localparam int NKEYS     = ROWS * COLS;
  localparam int MASK_BITS = 24;

  localparam int ROW_W   = 2;
  localparam int LEVEL_W = 6;
  localparam int TIME_W  = 32;
  localparam int DEB_W   = 16;

  localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RAM_DEPTH = 1 << ROW_AW;
  localparam int STAMP_W   = COLS * TIME_W;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic [DEB_W-1:0] DEB_RESET = 16'd50;

endpackage

// ----- sv/kmds_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module kmds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; a read at the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/key_matrix_debounce_scan_unit.sv -----
// Top level of the key matrix debounce scan unit.
//
// Usage: each transaction on the s_axis side is one scanned row of a keyboard
// half: s_axis_tdata holds row_index, column_levels (low = pressed) and
// now_ms. Each transaction yields one m_axis transaction with row_changed
// and the packed 24-bit debounced mask of the half (bit row*COLS+col).
// cfg_we/cfg_wdata load the 16-bit debounce time in ms (reset value 50).
// Per-key change stamps live in a RAM with one row of COLS 32-bit stamps per
// matrix row; pressed bits live in flip-flops so the whole mask is at hand.
// Flow: a row entering the judge stage reads its stamps, is judged there by
// six parallel compare cells, and the result register shows it on m_axis.
// Throughput: one row per cycle unless stalled; the stamp read-modify-write
// of a row is forwarded from a hold register when the next row is the same.
// Reset: debounce time returns to 50, all keys released, all stamps read as
// zero through per-row valid bits; no clearing pass is needed.
// Stall: while m_axis_tready is low the result register holds, the row in
// the judge stage waits, and s_axis keeps taking a row while that stage is
// free.
module key_matrix_debounce_scan_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [kmds_pkg::DEB_W-1:0]         cfg_wdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] row_index, [7:2] column_levels, [39:8] now_ms
  input  logic [kmds_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] row_changed, [24:1] half_key_mask, [31:25] zero
  output logic [kmds_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

`include "key_matrix_debounce_scan_unit_macros.svh"

  logic [kmds_pkg::DEB_W-1:0]     lockout_ms;
  logic [kmds_pkg::NKEYS-1:0]     key_pressed;
  logic [kmds_pkg::NKEYS-1:0]     key_pressed_next;
  logic [kmds_pkg::RAM_DEPTH-1:0] row_valid;

  logic                           s1_valid;
  logic [kmds_pkg::ROW_W-1:0]     s1_row;
  logic [kmds_pkg::LEVEL_W-1:0]   s1_levels;
  logic [kmds_pkg::TIME_W-1:0]    s1_now;
  logic                           s1_adv;
  logic                           s1_commit;
  logic                           s1_row_ok;
  logic [kmds_pkg::ROW_AW-1:0]    s1_addr;

  logic                           hold_valid;
  logic [kmds_pkg::ROW_AW-1:0]    hold_row;
  logic [kmds_pkg::STAMP_W-1:0]   hold_data;

  logic [kmds_pkg::STAMP_W-1:0]   ram_rdata;
  logic [kmds_pkg::STAMP_W-1:0]   stamps;
  logic [kmds_pkg::STAMP_W-1:0]   stamps_next;
  logic [kmds_pkg::TIME_W-1:0]    limit;
  logic                           changed;

  logic                           out_valid;
  logic                           out_changed;
  logic [kmds_pkg::MASK_BITS-1:0] out_mask;
  logic [kmds_pkg::MASK_BITS-1:0] mask_next;
  logic [kmds_pkg::MASK_BITS-1:0] mask_now;

  logic                           in_fire;
  logic [kmds_pkg::ROW_W-1:0]     in_row;

  // Handshake: judge stage advances when the result register is free
  assign s1_adv        = !out_valid || m_axis_tready;
  assign s1_commit     = s1_valid && s1_adv;
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_row        = s_axis_tdata[kmds_pkg::ROW_W-1:0];

  assign s1_row_ok = ({1'b0, s1_row} < (kmds_pkg::ROW_W + 1)'(kmds_pkg::ROWS));
  assign s1_addr   = kmds_pkg::ROW_AW'(s1_row);

  // Stamp store, one entry per matrix row
  kmds_ram #(
    .WIDTH (kmds_pkg::STAMP_W),
    .DEPTH (kmds_pkg::RAM_DEPTH)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (s1_commit && s1_row_ok),
    .waddr (s1_addr),
    .wdata (stamps_next),
    .re    (in_fire),
    .raddr (kmds_pkg::ROW_AW'(in_row)),
    .rdata (ram_rdata)
  );

  // Pick current stamps: forward the last write, else RAM or reset value
  always_comb begin
    if (hold_valid && (hold_row == s1_addr)) begin
      stamps = hold_data;
    end else if (row_valid[s1_addr]) begin
      stamps = ram_rdata;
    end else begin
      stamps = '0;
    end
  end

  assign limit = s1_now - {{(kmds_pkg::TIME_W - kmds_pkg::DEB_W){1'b0}}, lockout_ms};

  // Compare cells: one per column of the row
  always_comb begin
    int  k;
    logic lvl;
    key_pressed_next = key_pressed;
    stamps_next      = stamps;
    changed          = 1'b0;
    for (int c = 0; c < kmds_pkg::COLS; c++) begin
      k = int'(s1_row) * kmds_pkg::COLS + c;
      if (c < kmds_pkg::LEVEL_W) begin
        lvl = ~s1_levels[c % kmds_pkg::LEVEL_W];
      end else begin
        lvl = 1'b1;
      end
      if (s1_row_ok && (k < kmds_pkg::NKEYS)) begin
        if (!(stamps[c*kmds_pkg::TIME_W +: kmds_pkg::TIME_W] > limit)) begin
          if (lvl != key_pressed[k]) begin
            key_pressed_next[k] = lvl;
            stamps_next[c*kmds_pkg::TIME_W +: kmds_pkg::TIME_W] = s1_now;
            changed = 1'b1;
          end
        end
      end
    end
  end

  // Pack the visible part of the key state
  always_comb begin
    for (int i = 0; i < kmds_pkg::MASK_BITS; i++) begin
      if (i < kmds_pkg::NKEYS) begin
        mask_next[i] = key_pressed_next[i % kmds_pkg::NKEYS];
        mask_now[i]  = key_pressed[i % kmds_pkg::NKEYS];
      end else begin
        mask_next[i] = 1'b0;
        mask_now[i]  = 1'b0;
      end
    end
  end

  // Control state: config, key bits, valid bits, stage and output flags
  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ms  <= kmds_pkg::DEB_RESET;
      key_pressed <= '0;
      row_valid   <= '0;
      hold_valid  <= 1'b0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        lockout_ms <= cfg_wdata;
      end
      if (s1_commit) begin
        key_pressed <= key_pressed_next;
        if (s1_row_ok) begin
          row_valid[s1_addr] <= 1'b1;
          hold_valid         <= 1'b1;
        end
      end
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Payload: stage fields, forwarding copy and result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_row    <= in_row;
      s1_levels <= s_axis_tdata[kmds_pkg::ROW_W +: kmds_pkg::LEVEL_W];
      s1_now    <= s_axis_tdata[kmds_pkg::ROW_W + kmds_pkg::LEVEL_W +: kmds_pkg::TIME_W];
    end
    if (s1_commit && s1_row_ok) begin
      hold_row  <= s1_addr;
      hold_data <= stamps_next;
    end
    if (s1_commit) begin
      out_changed <= changed;
      out_mask    <= mask_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(kmds_pkg::OUT_DATA_W - kmds_pkg::MASK_BITS - 1){1'b0}},
                          out_mask, out_changed};

  // Assertions
  `KMDS_ASSERT(a_out_mask_live, !out_valid || (out_mask == mask_now),
               "held result mask differs from key state")
  `KMDS_ASSERT_NEXT(a_key_hold_on_stall, out_valid && !m_axis_tready,
                    $stable(key_pressed), "key state changed while result stalled")
  `KMDS_ASSERT(a_hold_row_valid, !hold_valid || row_valid[hold_row],
               "forwarded row not marked valid")
  `KMDS_ASSERT_NEXT(a_change_needs_row, s1_commit && changed,
                    key_pressed != $past(key_pressed), "change flag without key update")

endmodule

// ----- tb/sv/key_matrix_debounce_scan_unit_test.sv -----
// Self-checking testbench for the key matrix debounce scan unit.
`timescale 1ns / 100ps

module key_matrix_debounce_scan_unit_test;
  import kmds_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ROWS  = 160;

  typedef struct packed {
    logic [OUT_DATA_W-MASK_BITS-2:0] pad;
    logic [MASK_BITS-1:0]            mask;
    logic                            changed;
  } scan_result_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [LEVEL_W-1:0]   levels;
    logic [TIME_W-1:0]    now;
    logic                 typed;
    logic [MASK_BITS-1:0] mask;
    logic                 changed;
  } directed_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [DEB_W-1:0]      cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Local copy of the debounce state
  logic [DEB_W-1:0]  lockout_ms = DEB_RESET;
  logic              key_down [NKEYS];
  logic [TIME_W-1:0] change_stamp [NKEYS];

  scan_result_t  pending_scans [$];
  directed_row_t plan [18];
  logic [LEVEL_W-1:0] row_levels [ROWS];
  logic [TIME_W-1:0]  clock_ms = '0;
  logic [ROW_W-1:0]   last_row = '0;
  bit   steady = 1'b0;
  int   error_count = 0;
  int   idle_cycles = 0;

  key_matrix_debounce_scan_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Debounce one scanned row and return the row flag and the packed mask
  function automatic scan_result_t scan_row(input logic [ROW_W-1:0] row,
                                            input logic [LEVEL_W-1:0] levels,
                                            input logic [TIME_W-1:0] now);
    scan_result_t res;
    logic [TIME_W-1:0] limit;
    logic level_down;
    int k;
    res = '0;
    limit = now - TIME_W'(lockout_ms);
    if (int'(row) < ROWS) begin
      for (int col = 0; col < COLS; col++) begin
        k = int'(row) * COLS + col;
        if (k >= NKEYS) break;
        // Skip keys still inside their lockout window
        if (change_stamp[k] > limit) continue;
        level_down = (col < LEVEL_W) ? ~levels[col % LEVEL_W] : 1'b1;
        if (level_down != key_down[k]) begin
          key_down[k] = level_down;
          change_stamp[k] = now;
          res.changed = 1'b1;
        end
      end
    end
    for (int i = 0; i < NKEYS && i < MASK_BITS; i++) res.mask[i] = key_down[i];
    return res;
  endfunction

  // Offer one row sample, hold it until taken, then queue its expected result
  task automatic send_scan(input logic [ROW_W-1:0] row, input logic [LEVEL_W-1:0] levels,
                           input logic [TIME_W-1:0] now, input bit typed,
                           input scan_result_t given);
    scan_result_t predicted;
    if (!steady && $urandom_range(0, 99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, levels, row};
    do @(posedge clk); while (!s_axis_tready);
    predicted = scan_row(row, levels, now);
    pending_scans.push_back(typed ? given : predicted);
  endtask

  // Drain the pipeline, then load a new lockout time
  task automatic set_lockout(input logic [DEB_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    lockout_ms = value;
  endtask

  // Scan rows in order with key bounce and advancing time, plus some noise
  task automatic run_phase(input logic [DEB_W-1:0] value, input logic [TIME_W-1:0] start);
    int kind;
    int span;
    logic [ROW_W-1:0]   row;
    logic [LEVEL_W-1:0] levels;
    logic [TIME_W-1:0]  now;
    set_lockout(value);
    clock_ms = start;
    span = int'(value) / 4 + 3;
    for (int i = 0; i < PHASE_ROWS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        row    = ROW_W'($urandom);
        levels = LEVEL_W'($urandom);
        now    = $urandom;
      end else begin
        row = (kind < 25) ? ROW_W'($urandom) : last_row + 1'b1;
        if ($urandom_range(0, 2) == 0)
          row_levels[row] ^= LEVEL_W'($urandom) & LEVEL_W'($urandom);
        if (kind < 15) clock_ms = $urandom;
        else clock_ms += TIME_W'($urandom_range(0, span));
        levels   = row_levels[row];
        now      = clock_ms;
        last_row = row;
      end
      send_scan(row, levels, now, 1'b0, '0);
    end
  endtask

  // Check each result against the oldest expectation, then pick the next ready
  always @(posedge clk) begin : check_results
    scan_result_t got;
    scan_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_scans.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got);
        error_count++;
      end else begin
        want = pending_scans.pop_front();
        if (got.changed !== want.changed) begin
          $display("%0t: row_changed expected %0b actual %0b", $time, want.changed,
                   got.changed);
          error_count++;
        end
        if (got.mask !== want.mask) begin
          $display("%0t: half_key_mask expected %h actual %h", $time, want.mask, got.mask);
          error_count++;
        end
        if (got.pad !== want.pad) begin
          $display("%0t: padding expected %h actual %h", $time, want.pad, got.pad);
          error_count++;
        end
      end
    end
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 19);
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NKEYS; i++) begin
      key_down[i]     = 1'b0;
      change_stamp[i] = '0;
    end
    for (int r = 0; r < ROWS; r++) row_levels[r] = '1;

    // row, levels, now, typed, mask, changed
    plan = '{
      // idle after reset, then all keys of the edge rows down at time zero
      '{2'd0, 6'h3F, 32'h0000_0000, 1'b1, 24'h000000, 1'b0},
      '{2'd0, 6'h00, 32'h0000_0000, 1'b1, 24'h00003F, 1'b1},
      '{2'd3, 6'h00, 32'h0000_0000, 1'b1, 24'hFC003F, 1'b1},
      '{2'd1, 6'h2A, 32'h0000_0000, 1'b1, 24'hFC057F, 1'b1},
      // early time after reset: the wrapping window does not lock out
      '{2'd0, 6'h3F, 32'h0000_000A, 1'b0, 24'h0, 1'b0},
      '{2'd0, 6'h00, 32'h0000_0014, 1'b0, 24'h0, 1'b0},
      // bounce inside the lockout, then release right at its end
      '{2'd2, 6'h15, 32'h0000_03E8, 1'b0, 24'h0, 1'b0},
      '{2'd2, 6'h2A, 32'h0000_03FC, 1'b0, 24'h0, 1'b0},
      '{2'd2, 6'h2A, 32'h0000_041A, 1'b0, 24'h0, 1'b0},
      '{2'd2, 6'h3F, 32'h0000_0419, 1'b0, 24'h0, 1'b0},
      // time counter wrap across the lockout
      '{2'd3, 6'h3F, 32'hFFFF_FFFF, 1'b0, 24'h0, 1'b0},
      '{2'd3, 6'h00, 32'h0000_0010, 1'b0, 24'h0, 1'b0},
      '{2'd3, 6'h00, 32'h0000_0031, 1'b0, 24'h0, 1'b0},
      '{2'd1, 6'h3F, 32'h8000_0000, 1'b0, 24'h0, 1'b0},
      '{2'd1, 6'h00, 32'h7FFF_FFFF, 1'b0, 24'h0, 1'b0},
      // single columns on rows 0 to 2
      '{2'd0, 6'h3E, 32'hFFFF_FFCE, 1'b0, 24'h0, 1'b0},
      '{2'd1, 6'h1F, 32'h5555_5555, 1'b0, 24'h0, 1'b0},
      '{2'd2, 6'h3B, 32'hAAAA_AAAA, 1'b0, 24'h0, 1'b0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send_scan(plan[i].row, plan[i].levels, plan[i].now, plan[i].typed,
                '{pad: '0, mask: plan[i].mask, changed: plan[i].changed});

    // Sweep the lockout through its extremes and a few values between
    run_phase(16'd0, 32'd100);
    run_phase(16'd1, $urandom);
    steady = 1'b1;
    run_phase(16'hFFFF, 32'hFFFF_0000);
    steady = 1'b0;
    run_phase(16'($urandom_range(2, 200)), $urandom);
    run_phase(DEB_RESET, 32'd0);

    // Let the last results drain
    s_axis_tvalid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/kmds_pkg.sv
sv/kmds_ram.sv
sv/key_matrix_debounce_scan_unit.sv
tb/sv/key_matrix_debounce_scan_unit_test.sv
